### rtl/ihp_pkg.sv
// Package for the IPv4 header parser: item structs, status codes and field constants.
// Used by ipv4_header_parser; depends on nothing.
package ihp_pkg;

	localparam int unsigned DefaultMaxPacketBytes = 16384;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SHORT     = 2'd1;
	localparam logic [1:0] STATUS_BAD_VER   = 2'd2;
	localparam logic [1:0] STATUS_BAD_LEN   = 2'd3;

	localparam logic [3:0] IP_VERSION       = 4'd4;
	localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;
	localparam int unsigned MinCaptureBytes = 10;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [13:0] start_offset;
	} ihp_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  header_length;
		logic [15:0] total_length;
		logic [15:0] identification;
		logic [12:0] fragment_offset;
		logic        more_fragments;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol_number;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [14:0] payload_offset;
		logic [15:0] payload_length;
	} ihp_out_t;

endpackage

### rtl/ipv4_header_parser.sv
// IPv4 header parser top level: byte counter, header field capture and result register.
// Depends on ihp_pkg for the item structs and status codes.
//
// Usage:
// The input channel (item_valid, item_stall, item) carries one byte of a captured
// packet per item, with a mark on the packet's last byte. The start_offset field
// is sampled on the first byte of each packet and tells where the IPv4 header
// begins. The output channel (result_valid, result_stall, result) carries exactly
// one result per packet, produced from the marked last byte.
// An accepted item is held in the input register, where the byte counter and
// field capture are updated; a last byte writes the result register as it leaves
// the input register, and the result is offered from there. Throughput is one byte
// per cycle, set by the single input register feeding the capture logic, while no
// last byte waits on a result register that the receiver is stalling.
// Stalls: when the receiver stalls, the pending result stays in the result
// register. Ordinary bytes keep flowing through the capture logic meanwhile; only
// the next last byte waits in the input register, and item_stall is raised.
// Reset clears the counter, all captured fields and both valid flags; the first
// item after reset starts a new packet. Bytes past MAX_PACKET_BYTES are ignored.
module ipv4_header_parser
	import ihp_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = DefaultMaxPacketBytes
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  ihp_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output ihp_out_t result
);

	// Counter width holds MAX_PACKET_BYTES itself; CW covers offset plus header length.
	localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int unsigned CW    = ((POS_W > 14) ? POS_W : 14) + 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

	// Input register.
	logic    in_valid_s1;
	ihp_in_t in_s1;

	// Result register.
	logic     out_valid_s2;
	ihp_out_t out_s2;

	// Packet state.
	logic [POS_W-1:0] pos_q;
	logic [13:0]      hstart_q;
	logic [7:0]       fhb_q;
	logic [15:0]      len_q;
	logic [15:0]      ident_q;
	logic [15:0]      frag_q;
	logic [7:0]       ttl_q;
	logic [7:0]       proto_q;
	logic [31:0]      src_q;
	logic [31:0]      dst_q;

	logic [POS_W-1:0] pos_n;
	logic [13:0]      hstart_n;
	logic [7:0]       fhb_n;
	logic [15:0]      len_n;
	logic [15:0]      ident_n;
	logic [15:0]      frag_n;
	logic [7:0]       ttl_n;
	logic [7:0]       proto_n;
	logic [31:0]      src_n;
	logic [31:0]      dst_n;

	logic          in_range;
	logic          hit;
	logic [CW-1:0] rel;
	logic          consume;
	logic          load_s1;
	logic          emit;

	logic [CW-1:0] n_ext;
	logic [CW-1:0] o_ext;
	logic [5:0]    hl;
	logic [CW-1:0] pay_off;
	logic [15:0]   declared;
	logic [15:0]   captured;
	ihp_out_t      res;

	// The held byte moves on unless it is a last byte and the result register is
	// still occupied by a result the receiver has not taken.
	assign consume    = in_valid_s1 && (!in_s1.last_byte || !out_valid_s2 || !result_stall);
	assign load_s1    = !in_valid_s1 || consume;
	assign item_stall = !load_s1;
	assign emit       = consume && in_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (load_s1) begin
			in_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			in_s1 <= item;
		end
	end

	// Position of this byte relative to the header start, and field capture.
	always_comb begin
		hstart_n = (pos_q == '0) ? in_s1.start_offset : hstart_q;
		in_range = pos_q < POS_MAX;
		rel      = CW'(pos_q) - CW'(hstart_n);
		hit      = in_range && (CW'(pos_q) >= CW'(hstart_n));
		pos_n    = in_range ? pos_q + POS_W'(1) : pos_q;

		fhb_n   = fhb_q;
		len_n   = len_q;
		ident_n = ident_q;
		frag_n  = frag_q;
		ttl_n   = ttl_q;
		proto_n = proto_q;
		src_n   = src_q;
		dst_n   = dst_q;

		if (hit) begin
			if (rel == CW'(0)) begin
				fhb_n = in_s1.data_byte;
			end else if (rel == CW'(2) || rel == CW'(3)) begin
				len_n = {len_q[7:0], in_s1.data_byte};
			end else if (rel == CW'(4) || rel == CW'(5)) begin
				ident_n = {ident_q[7:0], in_s1.data_byte};
			end else if (rel == CW'(6) || rel == CW'(7)) begin
				frag_n = {frag_q[7:0], in_s1.data_byte};
			end else if (rel == CW'(8)) begin
				ttl_n = in_s1.data_byte;
			end else if (rel == CW'(9)) begin
				proto_n = in_s1.data_byte;
			end else if (rel >= CW'(12) && rel <= CW'(15)) begin
				src_n = {src_q[23:0], in_s1.data_byte};
			end else if (rel >= CW'(16) && rel <= CW'(19)) begin
				dst_n = {dst_q[23:0], in_s1.data_byte};
			end
		end
	end

	// Header checks and result fields, from the state including this byte.
	always_comb begin
		n_ext    = CW'(pos_n);
		o_ext    = CW'(hstart_n);
		hl       = {fhb_n[3:0], 2'b00};
		pay_off  = o_ext + CW'(hl);
		declared = len_n - 16'(hl);
		captured = 16'(n_ext - pay_off);
		res      = '0;
		if (n_ext < o_ext + CW'(MinCaptureBytes)) begin
			res.status = STATUS_SHORT;
		end else if (fhb_n[7:4] != IP_VERSION || hl < MIN_HEADER_BYTES) begin
			res.status = STATUS_BAD_VER;
		end else if (len_n < 16'(hl) || n_ext < pay_off) begin
			res.status = STATUS_BAD_LEN;
		end else begin
			res.status          = STATUS_OK;
			res.header_length   = hl;
			res.total_length    = len_n;
			res.identification  = ident_n;
			res.fragment_offset = frag_n[12:0];
			res.more_fragments  = frag_n[13];
			res.time_to_live    = ttl_n;
			res.protocol_number = proto_n;
			res.source_addr     = src_n;
			res.dest_addr       = dst_n;
			res.payload_offset  = pay_off[14:0];
			res.payload_length  = (declared < captured) ? declared : captured;
		end
	end

	// Packet state: updated by every consumed byte, cleared after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hstart_q <= '0;
			fhb_q    <= '0;
			len_q    <= '0;
			ident_q  <= '0;
			frag_q   <= '0;
			ttl_q    <= '0;
			proto_q  <= '0;
			src_q    <= '0;
			dst_q    <= '0;
		end else if (consume) begin
			if (in_s1.last_byte) begin
				pos_q    <= '0;
				hstart_q <= '0;
				fhb_q    <= '0;
				len_q    <= '0;
				ident_q  <= '0;
				frag_q   <= '0;
				ttl_q    <= '0;
				proto_q  <= '0;
				src_q    <= '0;
				dst_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				hstart_q <= hstart_n;
				fhb_q    <= fhb_n;
				len_q    <= len_n;
				ident_q  <= ident_n;
				frag_q   <= frag_n;
				ttl_q    <= ttl_n;
				proto_q  <= proto_n;
				src_q    <= src_n;
				dst_q    <= dst_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (emit) begin
			out_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_s2 <= res;
		end
	end

	assign result_valid = out_valid_s2;
	assign result       = out_s2;

	// A result is never overwritten while the receiver is stalling it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && result_stall |-> !emit)
		else $error("pending result overwritten");

	// Error results carry zeros in the header length and payload fields.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.status != STATUS_OK |->
			out_s2.header_length == '0 && out_s2.payload_offset == '0 &&
			out_s2.payload_length == '0)
		else $error("error result has nonzero fields");

	// A good result always has a legal header length.
	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.status == STATUS_OK |->
			out_s2.header_length >= MIN_HEADER_BYTES &&
			out_s2.total_length >= 16'(out_s2.header_length))
		else $error("good result with bad header length");

	// The byte counter saturates at the packet limit.
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte counter past limit");

	// The input side stalls only when a last byte waits on an occupied result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> in_valid_s1 && in_s1.last_byte && out_valid_s2 && result_stall)
		else $error("input stalled without cause");

endmodule
